/* rtl/core/arrival_jitter_monitor_adaptive_depth_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the arrival jitter monitor
// Shared property forms, clocked on clk and quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef ARRIVAL_JITTER_MONITOR_ADAPTIVE_DEPTH_CORE_DEFINES_SVH
`define ARRIVAL_JITTER_MONITOR_ADAPTIVE_DEPTH_CORE_DEFINES_SVH

// Same-cycle implication.
`define AJM_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ajm: same-cycle check failed");

// Next-cycle implication.
`define AJM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ajm: next-cycle check failed");

`endif

/* rtl/core/ajm_pkg.sv */
// ----------------------------------------------------------------------------
// ajm_pkg
// Beat types, opcodes, register indexes and thresholds of the jitter monitor.
// ----------------------------------------------------------------------------
package ajm_pkg;

  typedef struct packed {
    logic        opcode;
    logic [63:0] now_time_us;
    logic [31:0] stream_tag;
    logic [63:0] capture_time_us;
    logic        in_steady;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] variance_us2;
    logic [7:0]  target_depth;
  } result_t;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_ADAPT   = 1'b1;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TARGET = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TARGET = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TARGET = 8'd3;

  localparam logic [15:0] STALE_LIMIT_RST = 16'd0;
  localparam logic [7:0]  START_TARGET_RST = 8'd4;
  localparam logic [7:0]  MAX_TARGET_RST = 8'd16;
  localparam logic [7:0]  MIN_TARGET_RST = 8'd2;

  localparam logic [31:0] HIGH_VAR = 32'd25_000_000;
  localparam logic [31:0] LOW_VAR = 32'd1_000_000;
  localparam logic [63:0] RAISE_GAP_US = 64'd1_000_000;
  localparam logic [63:0] LOW_HOLD_US = 64'd10_000_000;
  localparam logic [9:0]  US_PER_MS = 10'd1000;

endpackage

/* rtl/core/arrival_jitter_monitor_adaptive_depth_core.sv */
// ----------------------------------------------------------------------------
// Arrival jitter monitor with adaptive target depth
// Tracks inter-arrival intervals of one stream, keeps their variance and
// steps a target buffer depth between configured bounds.
// ----------------------------------------------------------------------------
//
//   channel | signals                          | direction | beat
//   --------+----------------------------------+-----------+------------------
//   item    | item_valid item_ready item       | in        | one command
//   result  | result_valid result_ready result | out       | one per command
//   cfg     | cfg_valid cfg_ready cfg_index    | in        | one register write
//           | cfg_data                         |           |
//
// An arrival that leaves two or more intervals in the window walks the
//   interval memory twice and runs the shared one-bit-per-cycle divider
//   twice (SUM_W and 64 steps), where SUM_W = 32 + clog2(WINDOW+1).
// One command is in flight at a time; item_ready is high only while idle.
// The result register lets a finished result wait while the next item enters.
// Reset (rst, synchronous) clears control state and loads register defaults.
// cfg_ready is always high; write registers only while the block is idle.
// ----------------------------------------------------------------------------
module arrival_jitter_monitor_adaptive_depth_core #(
  parameter int WINDOW = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  ajm_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output ajm_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ajm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ajm_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "arrival_jitter_monitor_adaptive_depth_core_defines.svh"

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = 32 + CNT_W;
  localparam int DVD_W = 64;
  localparam int STEP_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_STALE  = 9'b000000100,
    S_RECORD = 9'b000001000,
    S_SUM    = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_DEV    = 9'b001000000,
    S_ADAPT  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] stale_limit_ms;
  logic [7:0]  start_target;
  logic [7:0]  max_target;
  logic [7:0]  min_target;

  // Stream state.
  logic              have_stream;
  logic [31:0]       active_stream;
  logic              have_previous;
  logic [63:0]       previous_arrival;
  logic [SLOT_W-1:0] write_slot;
  logic [CNT_W-1:0]  fill_count;
  logic [31:0]       variance_reg;
  logic [7:0]        depth_target;
  logic [63:0]       low_since;
  logic [63:0]       last_raise;

  // Interval memory: one write port, one registered read port.
  logic [31:0] interval_ring [WINDOW];
  logic [31:0] ring_q;
  logic        ring_we;

  // Walk and datapath registers.
  ajm_pkg::item_t   item_q;
  logic [CNT_W-1:0] idx;
  logic             pend;
  logic             pend2;
  logic [63:0]      age;
  logic             age_borrow;
  logic             stale_en;
  logic             res_accepted;
  logic [SUM_W-1:0] sum;
  logic [31:0]      mean;
  logic [63:0]      prod;
  logic [63:0]      acc;

  // Shared divider: dividend/quotient shift register and remainder.
  logic [DVD_W-1:0]  dvd;
  logic [CNT_W-1:0]  div_rem;
  logic [STEP_W-1:0] div_steps;
  logic              div_var_mode;

  // Combinational helpers.
  logic              restart;
  logic [26:0]       stale_thr;
  logic              is_stale;
  logic [63:0]       gap;
  logic [31:0]       gap_sat;
  logic [CNT_W-1:0]  fill_after;
  logic              issue;
  logic              walk_done;
  logic [CNT_W:0]    div_trial;
  logic [CNT_W:0]    div_diff;
  logic              div_ge;
  logic [31:0]       dev_abs;
  logic [63:0]       dev_sq;
  logic [64:0]       acc_sum;
  logic              adapt_on;
  logic              want_raise;
  logic              raise_ok;
  logic              hold_met;
  logic [63:0]       raise_gap;
  logic [63:0]       low_gap;
  logic              result_load;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  // New or changed stream restarts the tracking state.
  assign restart = !have_stream || (item_q.stream_tag != active_stream);

  // age / 1000 > limit is the same as age >= (limit + 1) * 1000.
  assign stale_thr = ({11'd0, stale_limit_ms} + 27'd1) * {17'd0, ajm_pkg::US_PER_MS};
  assign is_stale  = stale_en && !age_borrow && (age >= {37'd0, stale_thr});

  // Interval since the previous arrival, wrapped at 64 bits, clamped to 32.
  assign gap     = item_q.now_time_us - previous_arrival;
  assign gap_sat = (gap[63:32] != 32'd0) ? 32'hFFFF_FFFF : gap[31:0];
  assign fill_after = (have_previous && (fill_count < FILL_MAX)) ?
                      fill_count + CNT_W'(1) : fill_count;
  assign ring_we = (state == S_RECORD) && have_previous;

  // Memory walk: issue one read a cycle; data lands in ring_q in the cycle after.
  assign issue     = ((state == S_SUM) || (state == S_DEV)) && (idx < fill_count);
  assign walk_done = (idx == fill_count) && !pend && !pend2;

  // Divider step: shift in one dividend bit, subtract the count if it fits.
  assign div_trial = {div_rem, dvd[DVD_W-1]};
  assign div_ge    = (div_trial >= {1'b0, fill_count});
  assign div_diff  = div_trial - {1'b0, fill_count};

  // Deviation about the truncated mean, squared in one registered multiply.
  assign dev_abs = (ring_q > mean) ? ring_q - mean : mean - ring_q;
  assign dev_sq  = dev_abs * dev_abs;
  assign acc_sum = {1'b0, acc} + {1'b0, prod};

  // Adapt decisions.
  assign adapt_on   = item_q.in_steady && (fill_count >= CNT_W'(2));
  assign want_raise = (variance_reg > ajm_pkg::HIGH_VAR) && (depth_target < max_target);
  assign raise_gap  = item_q.now_time_us - last_raise;
  assign low_gap    = item_q.now_time_us - low_since;
  assign raise_ok   = (last_raise == 64'd0) || (raise_gap > ajm_pkg::RAISE_GAP_US);
  assign hold_met   = (low_gap >= ajm_pkg::LOW_HOLD_US) && (depth_target > min_target);

  assign result_load = (state == S_DONE) && (!result_valid || result_ready);

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit_ms <= ajm_pkg::STALE_LIMIT_RST;
      start_target   <= ajm_pkg::START_TARGET_RST;
      max_target     <= ajm_pkg::MAX_TARGET_RST;
      min_target     <= ajm_pkg::MIN_TARGET_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ajm_pkg::REG_STALE_LIMIT:  stale_limit_ms <= cfg_data;
        ajm_pkg::REG_START_TARGET: start_target <= cfg_data[7:0];
        ajm_pkg::REG_MAX_TARGET:   max_target <= cfg_data[7:0];
        ajm_pkg::REG_MIN_TARGET:   min_target <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Interval memory.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      interval_ring[write_slot] <= gap_sat;
    end
    ring_q <= interval_ring[idx[SLOT_W-1:0]];
  end

  // Sequencer and stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      have_stream      <= 1'b0;
      active_stream    <= 32'd0;
      have_previous    <= 1'b0;
      previous_arrival <= 64'd0;
      write_slot       <= '0;
      fill_count       <= '0;
      variance_reg     <= 32'd0;
      depth_target     <= ajm_pkg::START_TARGET_RST;
      low_since        <= 64'd0;
      last_raise       <= 64'd0;
      idx              <= '0;
      pend             <= 1'b0;
      pend2            <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      pend  <= issue;
      pend2 <= (state == S_DEV) && pend;
      if (issue) begin
        idx <= idx + CNT_W'(1);
      end
      // Raise the result beat when a new one lands; drop it once taken.
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= (item.opcode == ajm_pkg::OP_ADAPT) ? S_ADAPT : S_CHECK;
          end
        end
        S_CHECK: begin
          // Restart happens even when the packet goes on to be dropped.
          if (restart) begin
            have_stream      <= 1'b1;
            active_stream    <= item_q.stream_tag;
            have_previous    <= 1'b0;
            previous_arrival <= 64'd0;
            write_slot       <= '0;
            fill_count       <= '0;
            variance_reg     <= 32'd0;
            depth_target     <= start_target;
            low_since        <= 64'd0;
            last_raise       <= 64'd0;
          end
          state <= S_STALE;
        end
        S_STALE: begin
          state <= is_stale ? S_DONE : S_RECORD;
        end
        S_RECORD: begin
          if (have_previous) begin
            write_slot <= (write_slot == SLOT_LAST) ? '0 : write_slot + SLOT_W'(1);
          end
          fill_count       <= fill_after;
          have_previous    <= 1'b1;
          previous_arrival <= item_q.now_time_us;
          idx              <= '0;
          state            <= (fill_after >= CNT_W'(2)) ? S_SUM : S_DONE;
        end
        S_SUM: begin
          if (walk_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_steps == '0) begin
            if (div_var_mode) begin
              // Clamp the quotient to 32 bits.
              variance_reg <= (dvd[63:32] != 32'd0) ? 32'hFFFF_FFFF : dvd[31:0];
              state        <= S_DONE;
            end else begin
              idx   <= '0;
              state <= S_DEV;
            end
          end
        end
        S_DEV: begin
          if (walk_done) begin
            state <= S_DIV;
          end
        end
        S_ADAPT: begin
          if (adapt_on) begin
            if (want_raise) begin
              // Rate limit: hold everything when the last raise is too recent.
              if (raise_ok) begin
                depth_target <= depth_target + 8'd1;
                last_raise   <= item_q.now_time_us;
                low_since    <= 64'd0;
              end
            end else if (variance_reg < ajm_pkg::LOW_VAR) begin
              if (low_since == 64'd0) begin
                low_since <= item_q.now_time_us;
              end else if (hold_met) begin
                depth_target <= depth_target - 8'd1;
                low_since    <= 64'd0;
              end
            end else begin
              low_since <= 64'd0;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (result_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      item_q       <= item;
      res_accepted <= 1'b1;
    end
    if (state == S_CHECK) begin
      {age_borrow, age} <= {1'b0, item_q.now_time_us} - {1'b0, item_q.capture_time_us};
      stale_en <= (stale_limit_ms != 16'd0) && (item_q.capture_time_us != 64'd0);
    end
    if (state == S_STALE && is_stale) begin
      res_accepted <= 1'b0;
    end
    if (state == S_RECORD) begin
      sum <= '0;
    end
    if (state == S_SUM) begin
      if (pend) begin
        sum <= sum + SUM_W'(ring_q);
      end
      // Load the window sum into the top of the divider for the mean.
      if (walk_done) begin
        dvd          <= {sum, {(DVD_W - SUM_W){1'b0}}};
        div_rem      <= '0;
        div_steps    <= STEP_W'(SUM_W);
        div_var_mode <= 1'b0;
      end
    end
    if (state == S_DIV) begin
      if (div_steps != '0) begin
        dvd       <= {dvd[DVD_W-2:0], div_ge};
        div_rem   <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
        div_steps <= div_steps - STEP_W'(1);
      end else if (!div_var_mode) begin
        mean <= dvd[31:0];
        acc  <= 64'd0;
      end
    end
    if (state == S_DEV) begin
      if (pend) begin
        prod <= dev_sq;
      end
      // Saturate the running sum of squares at 64 bits.
      if (pend2) begin
        acc <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
      end
      if (walk_done) begin
        dvd          <= acc;
        div_rem      <= '0;
        div_steps    <= STEP_W'(DVD_W);
        div_var_mode <= 1'b1;
      end
    end
    if (result_load) begin
      result.accepted     <= res_accepted;
      result.variance_us2 <= variance_reg;
      result.target_depth <= depth_target;
    end
  end

  `AJM_ASSERT(a_fill_bound, 1'b1, fill_count <= FILL_MAX)
  `AJM_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, state != S_IDLE)
  `AJM_ASSERT(a_rem_below_count, state == S_DIV, div_rem < fill_count)
  `AJM_ASSERT(a_acc_monotone, state == S_DEV && $past(state) == S_DEV, acc >= $past(acc))

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the arrival jitter monitor core
// Drives arrival and adapt beats through the item channel and mirrors the
// interval window, variance and target depth in a local predictor. Every
// result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WINDOW = 16;
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off to back up the core
  localparam int SETTLE_CYCLES = 200;    // above the slowest arrival
  localparam int TIMEOUT_TIME = 2_000_000;
  localparam logic [ajm_pkg::CFG_IDX_W-1:0] BAD_INDEX_NEXT =
    ajm_pkg::REG_MIN_TARGET + 1'b1;
  localparam logic [ajm_pkg::CFG_IDX_W-1:0] BAD_INDEX_TOP = '1;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  ajm_pkg::item_t item_beat = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  ajm_pkg::result_t result_beat;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ajm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ajm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  arrival_jitter_monitor_adaptive_depth_core #(
    .WINDOW(WINDOW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item_beat),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result_beat),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle rates in percent, changed only between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_request = 1'b0;
  int stall_left = 0;
  bit run_failed = 1'b0;

  ajm_pkg::result_t expected_reports[$];

  // --------------------------------------------------------------------------
  // Predictor: register copies and monitor state
  // --------------------------------------------------------------------------
  logic [15:0] cfg_stale;
  logic [7:0] cfg_start;
  logic [7:0] cfg_max;
  logic [7:0] cfg_min;

  logic [31:0] gap_ring [WINDOW];
  int ring_wr;
  int ring_fill;
  bit prev_known;
  logic [63:0] prev_time;
  bit stream_known;
  logic [31:0] tracked_tag;
  logic [31:0] jitter_var;
  logic [7:0] depth;
  logic [63:0] low_start;     // 0 means no low-variance hold running
  logic [63:0] raise_time;    // 0 means no raise yet

  // Stimulus clock and the stream that the current burst belongs to.
  logic [63:0] wall_us = 64'h0000_0000_4000_0000;
  logic [31:0] burst_tag = 32'h0000_0100;

  function automatic void clear_window();
    for (int i = 0; i < WINDOW; i++) gap_ring[i] = '0;
    ring_wr = 0;
    ring_fill = 0;
    prev_known = 1'b0;
    prev_time = '0;
    jitter_var = '0;
    low_start = '0;
    raise_time = '0;
  endfunction

  function automatic void model_reset();
    cfg_stale = ajm_pkg::STALE_LIMIT_RST;
    cfg_start = ajm_pkg::START_TARGET_RST;
    cfg_max = ajm_pkg::MAX_TARGET_RST;
    cfg_min = ajm_pkg::MIN_TARGET_RST;
    clear_window();
    stream_known = 1'b0;
    tracked_tag = '0;
    depth = ajm_pkg::START_TARGET_RST;
  endfunction

  // Population variance of the held intervals: truncated mean, saturating
  // sum of squares, then saturate the quotient to 32 bits.
  function automatic logic [31:0] window_variance();
    logic [63:0] total;
    logic [63:0] mean;
    logic [63:0] dev;
    logic [63:0] sq;
    logic [63:0] acc;
    logic [63:0] quot;
    total = '0;
    acc = '0;
    for (int i = 0; i < ring_fill; i++) total += gap_ring[i];
    mean = total / 64'(ring_fill);
    for (int i = 0; i < ring_fill; i++) begin
      dev = (gap_ring[i] > mean) ? gap_ring[i] - mean : mean - gap_ring[i];
      sq = dev * dev;
      if (acc > ~64'd0 - sq) begin
        acc = ~64'd0;
      end else begin
        acc += sq;
      end
    end
    quot = acc / 64'(ring_fill);
    return (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
  endfunction

  // Apply one accepted beat to the predicted state and return its result.
  function automatic ajm_pkg::result_t advance_monitor(ajm_pkg::item_t beat);
    ajm_pkg::result_t rep;
    logic [63:0] gap;
    logic [63:0] age;
    rep.accepted = 1'b1;
    if (beat.opcode == ajm_pkg::OP_ARRIVAL) begin
      // A new or changed stream restarts everything, even if the beat is dropped.
      if (!stream_known || beat.stream_tag != tracked_tag) begin
        clear_window();
        stream_known = 1'b1;
        tracked_tag = beat.stream_tag;
        depth = cfg_start;
      end
      age = beat.now_time_us - beat.capture_time_us;
      if (cfg_stale != '0 && beat.capture_time_us != '0 &&
          beat.now_time_us > beat.capture_time_us &&
          age / ajm_pkg::US_PER_MS > cfg_stale) begin
        rep.accepted = 1'b0;
      end else begin
        if (prev_known) begin
          gap = beat.now_time_us - prev_time;
          gap_ring[ring_wr] = (gap > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
          ring_wr = (ring_wr + 1) % WINDOW;
          if (ring_fill < WINDOW) ring_fill++;
        end
        prev_known = 1'b1;
        prev_time = beat.now_time_us;
        if (ring_fill >= 2) jitter_var = window_variance();
      end
    end else if (beat.in_steady && ring_fill >= 2) begin
      if (jitter_var > ajm_pkg::HIGH_VAR && depth < cfg_max) begin
        if (raise_time == '0 || beat.now_time_us - raise_time > ajm_pkg::RAISE_GAP_US) begin
          depth++;
          raise_time = beat.now_time_us;
          low_start = '0;
        end
      end else if (jitter_var < ajm_pkg::LOW_VAR) begin
        if (low_start == '0) begin
          low_start = beat.now_time_us;
        end else if (beat.now_time_us - low_start >= ajm_pkg::LOW_HOLD_US &&
                     depth > cfg_min) begin
          depth--;
          low_start = '0;
        end
      end else begin
        low_start = '0;
      end
    end
    rep.variance_us2 = jitter_var;
    rep.target_depth = depth;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Beat builders: fields that the opcode ignores carry random noise
  // --------------------------------------------------------------------------
  function automatic ajm_pkg::item_t arrival_beat(logic [63:0] stamp, logic [31:0] tag,
                                                  logic [63:0] cap);
    ajm_pkg::item_t beat;
    beat.opcode = ajm_pkg::OP_ARRIVAL;
    beat.now_time_us = stamp;
    beat.stream_tag = tag;
    beat.capture_time_us = cap;
    beat.in_steady = 1'($urandom_range(0, 1));
    return beat;
  endfunction

  function automatic ajm_pkg::item_t adapt_beat(logic [63:0] stamp, logic steady);
    ajm_pkg::item_t beat;
    beat.opcode = ajm_pkg::OP_ADAPT;
    beat.now_time_us = stamp;
    beat.stream_tag = $urandom;
    beat.capture_time_us = {$urandom, $urandom};
    beat.in_steady = steady;
    return beat;
  endfunction

  // --------------------------------------------------------------------------
  // Channel tasks
  // --------------------------------------------------------------------------
  // Offer one item beat and record its prediction once accepted. Valid stays
  // high into the next call unless the sender decides to idle first.
  task automatic send_item(input ajm_pkg::item_t beat);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    item_beat <= beat;
    do @(posedge clk); while (!item_ready);
    expected_reports.push_back(advance_monitor(beat));
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    if (item_valid) item_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // One register write beat; the predictor follows the same decode.
  task automatic write_reg(input logic [ajm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ajm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ajm_pkg::REG_STALE_LIMIT: cfg_stale = val;
      ajm_pkg::REG_START_TARGET: cfg_start = val[7:0];
      ajm_pkg::REG_MAX_TARGET: cfg_max = val[7:0];
      ajm_pkg::REG_MIN_TARGET: cfg_min = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each accepted beat, then pick the next ready value
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    ajm_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with nothing outstanding: %p", result_beat);
        run_failed = 1'b1;
      end else begin
        want = expected_reports.pop_front();
        if (result_beat.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, result_beat.accepted);
          run_failed = 1'b1;
        end
        if (result_beat.variance_us2 !== want.variance_us2) begin
          $error("variance_us2: expected %0d, got %0d",
                 want.variance_us2, result_beat.variance_us2);
          run_failed = 1'b1;
        end
        if (result_beat.target_depth !== want.target_depth) begin
          $error("target_depth: expected %0d, got %0d",
                 want.target_depth, result_beat.target_depth);
          run_failed = 1'b1;
        end
      end
    end
    // Hold ready low for a long stretch on request, otherwise stall at random.
    if (stall_request) begin
      stall_left = HOLD_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left != 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  // Variance, raise with its rate limit, low-variance hold and lowering,
  // middling variance, clock going backwards and zero timestamps.
  task automatic test_stream_adapt();
    logic [63:0] t_hi;
    logic [63:0] t_lo;
    t_hi = 64'hFFFF_0000_0000_0000;
    t_lo = 64'h0000_0001_0000_0000;
    send_item(adapt_beat(t_hi, 1'b1));                          // no stream yet
    send_item(arrival_beat(t_hi, 32'hA5A5_0001, '0));
    send_item(arrival_beat(t_hi + 1000, 32'hA5A5_0001, '0));
    send_item(arrival_beat(t_hi + 3000, 32'hA5A5_0001, '0));    // first variance
    send_item(adapt_beat(t_hi + 3500, 1'b1));                   // start low hold
    send_item(arrival_beat(t_hi + 1000, 32'hA5A5_0001, '0));    // clock backwards
    send_item(adapt_beat(t_hi + 5000, 1'b0));                   // not steady
    send_item(adapt_beat(t_hi + 6000, 1'b1));                   // raise
    send_item(adapt_beat(t_hi + 1_006_000, 1'b1));              // rate limited
    send_item(adapt_beat(t_hi + 1_006_001, 1'b1));              // raise again
    send_item(arrival_beat(t_lo, 32'h5A5A_FFFE, '0));           // stream change
    send_item(arrival_beat(t_lo + 2_000_000, 32'h5A5A_FFFE, '0));
    send_item(arrival_beat(t_lo + 4_000_000, 32'h5A5A_FFFE, '0));
    send_item(adapt_beat(t_lo + 4_000_000, 1'b1));              // start low hold
    send_item(adapt_beat(t_lo + 13_999_999, 1'b1));             // one short
    send_item(adapt_beat(t_lo + 14_000_000, 1'b1));             // lower
    send_item(adapt_beat('0, 1'b1));                            // zero stamp
    send_item(adapt_beat(t_lo + 30_000_000, 1'b1));             // start low hold
    send_item(arrival_beat(t_lo + 6_004_000, 32'h5A5A_FFFE, '0));
    send_item(adapt_beat(t_lo + 31_000_000, 1'b1));             // middling clears
    drain_results();
  endtask

  // Stale drop around the limit, future and unknown capture times.
  task automatic test_stale_drop();
    logic [63:0] base;
    base = 64'h0000_0000_1000_0000;
    drain_results();
    write_reg(ajm_pkg::REG_STALE_LIMIT, 16'd5);
    send_item(arrival_beat(base, 32'h0000_0C0C, base - 5999));          // age 5: keep
    send_item(arrival_beat(base + 10000, 32'h0000_0C0C, base + 4000));  // age 6: drop
    send_item(arrival_beat(base + 20000, 32'h0000_0C0C, base + 20007)); // future
    send_item(arrival_beat(base + 30000, 32'h0000_0C0C, base + 30000)); // same time
    send_item(arrival_beat(base + 40000, 32'h0000_0D0D, 64'd1));        // new stream, drop
    drain_results();
    write_reg(ajm_pkg::REG_STALE_LIMIT, 16'hFFFF);
    send_item(arrival_beat(base + 50000, 32'h0000_0D0D, base + 50000 - 65_535_999));
    send_item(arrival_beat(base + 60000, 32'h0000_0D0D, base + 60000 - 65_536_000));
    drain_results();
    write_reg(ajm_pkg::REG_STALE_LIMIT, 16'd0);
    send_item(arrival_beat(base + 70000, 32'h0000_0D0D, 64'd1));        // check off
    drain_results();
  endtask

  // Out-of-range indexes, target bounds at the extremes, and a start target
  // change that must wait for the next stream restart.
  task automatic test_register_writes();
    logic [63:0] base;
    base = 64'h0000_7FFF_0000_0000;
    drain_results();
    write_reg(BAD_INDEX_NEXT, '1);
    write_reg(BAD_INDEX_TOP, '1);
    write_reg(ajm_pkg::REG_START_TARGET, 16'd255);
    write_reg(ajm_pkg::REG_MAX_TARGET, 16'd1);
    write_reg(ajm_pkg::REG_MIN_TARGET, 16'd255);
    send_item(arrival_beat(base, 32'hFFFF_FFFF, base - 1000));
    send_item(arrival_beat(base + 1000, 32'hFFFF_FFFF, '0));
    send_item(arrival_beat(base + 90000, 32'hFFFF_FFFF, '0));
    send_item(adapt_beat(base + 90000, 1'b1));                  // raise blocked by max
    drain_results();
    write_reg(ajm_pkg::REG_START_TARGET, 16'd1);
    send_item(arrival_beat(base + 91000, 32'hFFFF_FFFF, '0));   // target holds
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------
  // One burst on one stream: a base period and a jitter spread pick the
  // variance regime; adapt beats land between arrivals. A few beats are
  // noise: stray tags, backwards steps, huge gaps, zero stamps.
  task automatic run_stream_burst(inout int sent);
    int len;
    int pick;
    int spread;
    logic [63:0] period;
    logic [63:0] stamp;
    logic [63:0] cap;
    if ($urandom_range(0, 2) == 0) begin
      burst_tag = $urandom;
      if ($urandom_range(0, 3) == 0) wall_us = {$urandom, $urandom};
    end
    case ($urandom_range(0, 3))
      0: period = 64'd20_000;
      1: period = 64'd2_000_000;
      2: period = 64'($urandom_range(900_000, 1_100_000));
      default: period = 64'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 800;
      2: spread = 12_000;
      default: spread = 250_000;
    endcase
    len = $urandom_range(4, 30);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if (pick < 2) begin
          wall_us += {24'd0, 8'($urandom_range(1, 255)), $urandom};  // saturating gap
        end else if (pick < 5) begin
          wall_us -= 64'($urandom_range(1, 50_000));
        end else begin
          wall_us += period + 64'($urandom_range(0, spread));
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3: cap = '0;
          4, 5, 6, 7: cap = wall_us -
                            64'($urandom_range(0, int'(cfg_stale) * 2000 + 3000));
          8: cap = {$urandom, $urandom};
          default: cap = wall_us + 64'($urandom_range(0, 5000));
        endcase
        send_item(arrival_beat(wall_us, ($urandom_range(0, 49) == 0) ? $urandom : burst_tag,
                               cap));
      end else begin
        stamp = (pick == 99) ? 64'd0 : wall_us + 64'($urandom_range(0, 1_500_000));
        send_item(adapt_beat(stamp, $urandom_range(0, 9) != 0));
      end
      sent++;
    end
  endtask

  task automatic test_jitter_traffic(input int send_pct, input int recv_pct,
                                     input logic [15:0] stale, input logic [7:0] start,
                                     input logic [7:0] top, input logic [7:0] bottom,
                                     input bit squeeze, input int count);
    int sent;
    sent = 0;
    drain_results();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_reg(ajm_pkg::REG_STALE_LIMIT, stale);
    write_reg(ajm_pkg::REG_START_TARGET, 16'(start));
    write_reg(ajm_pkg::REG_MAX_TARGET, 16'(top));
    write_reg(ajm_pkg::REG_MIN_TARGET, 16'(bottom));
    // Back up the core: the receiver holds off while items keep coming.
    if (squeeze) stall_request = 1'b1;
    while (sent < count) run_stream_burst(sent);
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    model_reset();
    send_idle_pct = 23;
    recv_idle_pct = 74;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_stream_adapt();
    test_stale_drop();
    test_register_writes();
    test_jitter_traffic(23, 74, 16'($urandom_range(1, 40)), 8'd6, 8'd12, 8'd3, 1'b0, 200);
    test_jitter_traffic(74, 23, 16'hFFFF, 8'd255, 8'd255, 8'd1, 1'b0, 200);
    test_jitter_traffic(0, 0, 16'd0, 8'd1, 8'd8, 8'd1, 1'b1, 200);
    drain_results();
    // Leave room for any stray result beat to show up.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!run_failed && expected_reports.size() == 0) begin
      $display("[arrival_jitter_monitor_adaptive_depth_core] OK");
    end else begin
      $display("[arrival_jitter_monitor_adaptive_depth_core] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_TIME);
    $display("[arrival_jitter_monitor_adaptive_depth_core] ERROR");
    $finish;
  end

endmodule
